@@ sv/lfk_pkg.sv @@
// Shared types and constants for the leg forward kinematics core.
package lfk_pkg;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;
  typedef logic [1:0]  joint_idx_t;

  // configuration register indexes
  localparam cfg_idx_t RegBodyHeight  = 3'd0;
  localparam cfg_idx_t RegOriginToHip = 3'd1;
  localparam cfg_idx_t RegHipOffsetX  = 3'd2;
  localparam cfg_idx_t RegHipOffsetZ  = 3'd3;
  localparam cfg_idx_t RegThighLength = 3'd4;
  localparam cfg_idx_t RegShinLength  = 3'd5;

  // result order
  localparam joint_idx_t JointHipYaw   = 2'd0;
  localparam joint_idx_t JointHipPitch = 2'd1;
  localparam joint_idx_t JointKnee     = 2'd2;
  localparam joint_idx_t JointToe      = 2'd3;

  // Q14 sine approximation
  localparam logic [31:0] Q14One  = 32'd16384;
  localparam logic [31:0] Q14Half = 32'd8192;
  localparam logic [31:0] PolyC1  = 32'd1160;
  localparam logic [31:0] PolyC2  = 32'd10512;
  localparam logic [31:0] PolyC3  = 32'd25736;

  // sine lanes: cos/sin of mount, yaw, pitch, knee
  localparam int NumLanes = 8;
  localparam int LaneCm = 0;
  localparam int LaneSm = 1;
  localparam int LaneCy = 2;
  localparam int LaneSy = 3;
  localparam int LaneCp = 4;
  localparam int LaneSp = 5;
  localparam int LaneCk = 6;
  localparam int LaneSk = 7;

  // round-half-up Q14 scaling: floor((p + 8192) / 16384)
  function automatic logic signed [27:0] rnd_q14(input logic signed [39:0] p);
    logic signed [39:0] s;
    s = (p + 40'sd8192) >>> 14;
    return s[27:0];
  endfunction

endpackage

@@ sv/lfk_if.sv @@
// Request and result channel interfaces of the leg forward kinematics core.
interface lfk_req_if #(
  parameter int ANGLE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic        [ANGLE_WIDTH-1:0] mount_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] knee_angle;

  modport source (output valid, mount_angle, yaw_angle, pitch_angle, knee_angle,
                  input ready);
  modport sink (input valid, mount_angle, yaw_angle, pitch_angle, knee_angle,
                output ready);
endinterface

interface lfk_res_if #(
  parameter int POS_WIDTH = 24
) ();
  logic                        valid;
  logic                        ready;
  logic                  [1:0] joint_index;
  logic signed [POS_WIDTH-1:0] leg_x;
  logic signed [POS_WIDTH-1:0] leg_y;
  logic signed [POS_WIDTH-1:0] leg_z;
  logic signed [POS_WIDTH-1:0] body_x;
  logic signed [POS_WIDTH-1:0] body_y;
  logic signed [POS_WIDTH-1:0] body_z;
  logic                 [15:0] rot_about_x;
  logic                 [15:0] rot_about_z;
  logic                        last_joint;

  modport source (output valid, joint_index, leg_x, leg_y, leg_z, body_x, body_y,
                  body_z, rot_about_x, rot_about_z, last_joint, input ready);
  modport sink (input valid, joint_index, leg_x, leg_y, leg_z, body_x, body_y,
                body_z, rot_about_x, rot_about_z, last_joint, output ready);
endinterface

@@ sv/leg_forward_kinematics_core.sv @@
// Leg forward kinematics core: ten-stage pipeline plus four-result serializer.
//
//   channel  dir  handshake            carries
//   req_i    in   valid/ready          mount, yaw, pitch, knee angles
//   res_o    out  valid/ready          joint index, leg/body xyz, rotations
//   cfg      in   cfg_we_i (no ready)  six 16-bit geometry registers
//
// The first result of each request is its hip yaw result, from stage 10.
// Each request yields four results, one per cycle while res_o is ready; the
// last stage holds a request until its toe result is taken, so the
// sustained request rate is set by the single result port.
// Reset clears valid bits, the result counter and the geometry registers.
// A stall on res_o backs up stage by stage; nothing is dropped or repeated.
module leg_forward_kinematics_core #(
  parameter int POS_WIDTH   = 24,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  lfk_pkg::cfg_idx_t  cfg_idx_i,
  input  lfk_pkg::cfg_data_t cfg_data_i,
  lfk_req_if.sink           req_i,
  lfk_res_if.source         res_o
);
  import lfk_pkg::*;

  localparam int NumSt = 10;
  localparam int AW    = ANGLE_WIDTH;
  localparam logic [AW-1:0] AngQuarter = {2'b01, {(AW-2){1'b0}}};
  localparam logic signed [32:0] PosMax = (33'sd1 <<< (POS_WIDTH-1)) - 33'sd1;
  localparam logic signed [32:0] PosMin = -PosMax - 33'sd1;

  // binary angle -> 16-bit phase
  function automatic logic [15:0] phase16(input logic [AW-1:0] a);
    logic [AW+7:0] w;
    w = {a, 8'h00};
    return 16'(w >> (AW-8));
  endfunction

  function automatic logic [POS_WIDTH-1:0] sat_pos(input logic signed [32:0] v);
    logic signed [32:0] c;
    c = v;
    if (v > PosMax) c = PosMax;
    if (v < PosMin) c = PosMin;
    return c[POS_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [15:0] body_height_q, origin_to_hip_q, thigh_q, shin_q;
  logic signed [15:0] hip_x_q, hip_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_height_q   <= '0;
      origin_to_hip_q <= '0;
      hip_x_q         <= '0;
      hip_z_q         <= '0;
      thigh_q         <= '0;
      shin_q          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBodyHeight:  body_height_q   <= cfg_data_i;
        RegOriginToHip: origin_to_hip_q <= cfg_data_i;
        RegHipOffsetX:  hip_x_q         <= $signed(cfg_data_i);
        RegHipOffsetZ:  hip_z_q         <= $signed(cfg_data_i);
        RegThighLength: thigh_q         <= cfg_data_i;
        RegShinLength:  shin_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  logic [NumSt:1] v_q, rdy, ld;
  joint_idx_t     cnt_q;

  // a stage accepts when empty or when its contents move on
  always_comb begin
    rdy[NumSt] = !v_q[NumSt] || (res_o.ready && cnt_q == JointToe);
    for (int k = NumSt-1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    ld[1] = req_i.valid && rdy[1];
    for (int k = 2; k <= NumSt; k++) begin
      ld[k] = v_q[k-1] && rdy[k];
    end
  end

  assign req_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      cnt_q <= JointHipYaw;
    end else begin
      if (rdy[1]) v_q[1] <= req_i.valid;
      for (int k = 2; k <= NumSt; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
      if (res_o.valid && res_o.ready) cnt_q <= cnt_q + 2'd1;
    end
  end

  // --------------------------------------------------------- angle sums
  // rxa: pitch, rxb: pitch + knee, rz: mount + yaw (all wrap)
  logic [AW-1:0] rxa_q [1:NumSt];
  logic [AW-1:0] rxb_q [1:NumSt];
  logic [AW-1:0] rz_q  [1:NumSt];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      rxa_q[1] <= $unsigned(req_i.pitch_angle);
      rxb_q[1] <= AW'($unsigned(req_i.pitch_angle) + $unsigned(req_i.knee_angle));
      rz_q[1]  <= AW'(req_i.mount_angle + $unsigned(req_i.yaw_angle));
    end
    for (int k = 2; k <= NumSt; k++) begin
      if (ld[k]) begin
        rxa_q[k] <= rxa_q[k-1];
        rxb_q[k] <= rxb_q[k-1];
        rz_q[k]  <= rz_q[k-1];
      end
    end
  end

  // ------------------------------------------------- sine, stages 1..5
  logic [AW-1:0] lane_ang [NumLanes];
  logic [14:0]   t_d      [NumLanes];
  logic [7:0]    neg_d;

  always_comb begin
    lane_ang[LaneCm] = AW'(req_i.mount_angle + AngQuarter);
    lane_ang[LaneSm] = req_i.mount_angle;
    lane_ang[LaneCy] = AW'($unsigned(req_i.yaw_angle) + AngQuarter);
    lane_ang[LaneSy] = $unsigned(req_i.yaw_angle);
    lane_ang[LaneCp] = AW'($unsigned(req_i.pitch_angle) + AngQuarter);
    lane_ang[LaneSp] = $unsigned(req_i.pitch_angle);
    lane_ang[LaneCk] = AW'($unsigned(req_i.knee_angle) + AngQuarter);
    lane_ang[LaneSk] = $unsigned(req_i.knee_angle);
    for (int l = 0; l < NumLanes; l++) begin
      // fold to first quadrant; odd quadrants mirror, upper half negates
      logic [15:0] ph;
      ph = phase16(lane_ang[l]);
      t_d[l]   = ph[14] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
      neg_d[l] = ph[15];
    end
  end

  logic [14:0] t_q [1:4][NumLanes];
  logic [7:0]  neg_q [1:4];
  logic [14:0] u_q [2:3][NumLanes];
  logic [13:0] i_q [NumLanes];
  logic [14:0] m_q [NumLanes];
  logic signed [15:0] s_q [5:8][NumLanes];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      t_q[1]   <= t_d;
      neg_q[1] <= neg_d;
    end
    for (int k = 2; k <= 4; k++) begin
      if (ld[k]) begin
        t_q[k]   <= t_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
    for (int l = 0; l < NumLanes; l++) begin
      if (ld[2]) u_q[2][l] <= 15'((32'(t_q[1][l]) * 32'(t_q[1][l]) + Q14Half) >> 14);
      if (ld[3]) begin
        u_q[3][l] <= u_q[2][l];
        i_q[l]    <= 14'(PolyC2 - ((32'(u_q[2][l]) * PolyC1 + Q14Half) >> 14));
      end
      if (ld[4]) m_q[l] <= 15'(PolyC3 - ((32'(u_q[3][l]) * 32'(i_q[l]) + Q14Half) >> 14));
      if (ld[5]) begin
        logic [15:0] p;
        p = 16'((32'(t_q[4][l]) * 32'(m_q[l]) + Q14Half) >> 14);
        s_q[5][l] <= neg_q[4][l] ? -$signed(p) : $signed(p);
      end
    end
    for (int k = 6; k <= 8; k++) begin
      if (ld[k]) s_q[k] <= s_q[k-1];
    end
  end

  // ------------------------------------------------ kinematics, stages 6..10
  logic signed [16:0] l1s, l2s, ohs, bhs;
  assign l1s = $signed({1'b0, thigh_q});
  assign l2s = $signed({1'b0, shin_q});
  assign ohs = $signed({1'b0, origin_to_hip_q});
  assign bhs = $signed({1'b0, body_height_q});

  // stage 6: a = thigh + shin*ck, b = shin*sk, thigh*cp, thigh*sp
  logic signed [18:0] a_q;
  logic signed [17:0] b_q, k1_q, k2_q;
  // stage 7: local x/z of hip pitch, knee, toe
  logic signed [19:0] px_q [3];
  logic signed [19:0] pz_q [3];
  // stage 8: leg-frame points
  logic signed [20:0] x8_q [4];
  logic signed [20:0] y8_q [4];
  logic signed [20:0] z8_q [4];
  // stage 9: mount rotation products, point carried along
  logic signed [20:0] x9_q [4];
  logic signed [20:0] y9_q [4];
  logic signed [20:0] z9_q [4];
  logic signed [21:0] xc_q [4];
  logic signed [21:0] xs_q [4];
  logic signed [21:0] yc_q [4];
  logic signed [21:0] ys_q [4];
  // stage 10: saturated result set
  logic [POS_WIDTH-1:0] lx_q [4];
  logic [POS_WIDTH-1:0] ly_q [4];
  logic [POS_WIDTH-1:0] lz_q [4];
  logic [POS_WIDTH-1:0] bx_q [4];
  logic [POS_WIDTH-1:0] by_q [4];

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      a_q  <= 19'(l1s + rnd_q14(l2s * s_q[5][LaneCk]));
      b_q  <= 18'(rnd_q14(l2s * s_q[5][LaneSk]));
      k1_q <= 18'(rnd_q14(l1s * s_q[5][LaneCp]));
      k2_q <= 18'(rnd_q14(l1s * s_q[5][LaneSp]));
    end
    if (ld[7]) begin
      px_q[0] <= 20'(hip_x_q);
      pz_q[0] <= 20'(hip_z_q);
      px_q[1] <= 20'(hip_x_q + k1_q);
      pz_q[1] <= 20'(hip_z_q - k2_q);
      px_q[2] <= 20'(hip_x_q + rnd_q14(a_q * s_q[6][LaneCp])
                    - rnd_q14(b_q * s_q[6][LaneSp]));
      pz_q[2] <= 20'(hip_z_q - rnd_q14(a_q * s_q[6][LaneSp])
                    - rnd_q14(b_q * s_q[6][LaneCp]));
    end
    if (ld[8]) begin
      // hip yaw joint sits at the hip mount itself
      x8_q[0] <= 21'(ohs);
      y8_q[0] <= '0;
      z8_q[0] <= 21'(bhs);
      for (int j = 0; j < 3; j++) begin
        x8_q[j+1] <= 21'(ohs + rnd_q14(px_q[j] * s_q[7][LaneCy]));
        y8_q[j+1] <= 21'(rnd_q14(px_q[j] * s_q[7][LaneSy]));
        z8_q[j+1] <= 21'(bhs + pz_q[j]);
      end
    end
    if (ld[9]) begin
      for (int j = 0; j < 4; j++) begin
        x9_q[j] <= x8_q[j];
        y9_q[j] <= y8_q[j];
        z9_q[j] <= z8_q[j];
        xc_q[j] <= 22'(rnd_q14(x8_q[j] * s_q[8][LaneCm]));
        xs_q[j] <= 22'(rnd_q14(x8_q[j] * s_q[8][LaneSm]));
        yc_q[j] <= 22'(rnd_q14(y8_q[j] * s_q[8][LaneCm]));
        ys_q[j] <= 22'(rnd_q14(y8_q[j] * s_q[8][LaneSm]));
      end
    end
    if (ld[10]) begin
      for (int j = 0; j < 4; j++) begin
        lx_q[j] <= sat_pos(33'(x9_q[j]));
        ly_q[j] <= sat_pos(33'(y9_q[j]));
        lz_q[j] <= sat_pos(33'(z9_q[j]));
        bx_q[j] <= sat_pos(33'(xc_q[j] - ys_q[j]));
        by_q[j] <= sat_pos(33'(xs_q[j] + yc_q[j]));
      end
    end
  end

  // ------------------------------------------------------- result port
  // body z equals leg z; the counter walks the four joints of the held set
  always_comb begin
    res_o.valid       = v_q[NumSt];
    res_o.joint_index = cnt_q;
    res_o.leg_x       = $signed(lx_q[cnt_q]);
    res_o.leg_y       = $signed(ly_q[cnt_q]);
    res_o.leg_z       = $signed(lz_q[cnt_q]);
    res_o.body_x      = $signed(bx_q[cnt_q]);
    res_o.body_y      = $signed(by_q[cnt_q]);
    res_o.body_z      = $signed(lz_q[cnt_q]);
    res_o.last_joint  = (cnt_q == JointToe);
    case (cnt_q)
      JointHipYaw: begin
        res_o.rot_about_x = '0;
        res_o.rot_about_z = 16'(rz_q[NumSt]);
      end
      JointHipPitch: begin
        res_o.rot_about_x = 16'(rxa_q[NumSt]);
        res_o.rot_about_z = 16'(rz_q[NumSt]);
      end
      JointKnee: begin
        res_o.rot_about_x = 16'(rxb_q[NumSt]);
        res_o.rot_about_z = 16'(rz_q[NumSt]);
      end
      default: begin
        res_o.rot_about_x = '0;
        res_o.rot_about_z = '0;
      end
    endcase
  end

  // ------------------------------------------------------------ checks
  // counter only moves while a result set is held
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NumSt] |-> cnt_q == JointHipYaw)
    else $error("result counter not at first joint with empty output stage");

  // the stage before the last keeps its item while stalled
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NumSt-1] && !rdy[NumSt] |=> v_q[NumSt-1])
    else $error("pipeline item lost under stall");

  // output set is only replaced after the toe result leaves
  a_hold_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !(res_o.ready && res_o.last_joint) |=> res_o.valid
      && $stable(rz_q[NumSt]))
    else $error("result set changed before toe result delivered");

endmodule

@@ test/lfk_scoreboard.sv @@
// Joint position predictor and result checker for the leg kinematics core.
class lfk_scoreboard;
  typedef struct packed {
    logic [1:0]         joint;
    logic signed [23:0] lx, ly, lz, bx, by, bz;
    logic [15:0]        rx, rz;
    logic               last;
  } joint_res_t;

  joint_res_t pending_joints[$];
  int         mismatch_cnt;
  logic [15:0] body_height, origin_to_hip, hip_off_x, hip_off_z, thigh_len, shin_len;

  function void clear_geometry();
    body_height = 0; origin_to_hip = 0; hip_off_x = 0; hip_off_z = 0;
    thigh_len = 0; shin_len = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      lfk_pkg::RegBodyHeight:  body_height   = val;
      lfk_pkg::RegOriginToHip: origin_to_hip = val;
      lfk_pkg::RegHipOffsetX:  hip_off_x     = val;
      lfk_pkg::RegHipOffsetZ:  hip_off_z     = val;
      lfk_pkg::RegThighLength: thigh_len     = val;
      lfk_pkg::RegShinLength:  shin_len      = val;
      default: ;
    endcase
  endfunction

  // Q14 sine from a 16-bit binary angle, quarter-wave polynomial
  function longint sine14(logic [15:0] ang);
    longint t, u, i, m, p;
    t = (ang[14]) ? 16384 - longint'(ang[13:0]) : longint'(ang[13:0]);
    u = (t * t + 8192) >>> 14;
    i = 10512 - ((u * 1160 + 8192) >>> 14);
    m = 25736 - ((u * i + 8192) >>> 14);
    p = (t * m + 8192) >>> 14;
    return ang[15] ? -p : p;
  endfunction

  function longint cosine14(logic [15:0] ang);
    return sine14(ang + 16'h4000);
  endfunction

  // floor((v*f + 8192) / 16384)
  function longint scale14(longint v, longint f);
    return (v * f + 8192) >>> 14;
  endfunction

  function logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function joint_res_t make_joint(logic [1:0] j, longint x, longint y, longint z,
                                  longint cm, longint sm, logic [15:0] rx, logic [15:0] rz);
    joint_res_t r;
    r.joint = j;
    r.lx = clamp24(x); r.ly = clamp24(y); r.lz = clamp24(z);
    r.bx = clamp24(scale14(x, cm) - scale14(y, sm));
    r.by = clamp24(scale14(x, sm) + scale14(y, cm));
    r.bz = clamp24(z);
    r.rx = rx; r.rz = rz;
    r.last = (j == lfk_pkg::JointToe);
    return r;
  endfunction

  function void queue_joint(joint_res_t r);
    pending_joints = {pending_joints, r};
  endfunction

  function void note_request(logic [15:0] am, ay, ap, ak);
    longint cm, sm, cy, sy, cp, sp, ck, sk, bh, oh, hx, hz, l1, l2, a, b;
    longint px[3], pz[3];
    logic [15:0] rz;
    cm = cosine14(am); sm = sine14(am); cy = cosine14(ay); sy = sine14(ay);
    cp = cosine14(ap); sp = sine14(ap); ck = cosine14(ak); sk = sine14(ak);
    bh = body_height; oh = origin_to_hip;
    hx = longint'($signed(hip_off_x)); hz = longint'($signed(hip_off_z));
    l1 = thigh_len; l2 = shin_len;
    a = l1 + scale14(l2, ck);
    b = scale14(l2, sk);
    px[0] = hx; pz[0] = hz;
    px[1] = hx + scale14(l1, cp); pz[1] = hz - scale14(l1, sp);
    px[2] = hx + scale14(a, cp) - scale14(b, sp);
    pz[2] = hz - scale14(a, sp) - scale14(b, cp);
    rz = am + ay;
    queue_joint(make_joint(lfk_pkg::JointHipYaw, oh, 0, bh, cm, sm, 16'd0, rz));
    queue_joint(make_joint(lfk_pkg::JointHipPitch, oh + scale14(px[0], cy),
      scale14(px[0], sy), bh + pz[0], cm, sm, ap, rz));
    queue_joint(make_joint(lfk_pkg::JointKnee, oh + scale14(px[1], cy),
      scale14(px[1], sy), bh + pz[1], cm, sm, ap + ak, rz));
    queue_joint(make_joint(lfk_pkg::JointToe, oh + scale14(px[2], cy),
      scale14(px[2], sy), bh + pz[2], cm, sm, 16'd0, 16'd0));
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  task check_joint(joint_res_t got);
    joint_res_t want;
    if (pending_joints.size() == 0) begin
      report("unexpected result, joint_index", got.joint, -1);
      return;
    end
    want = pending_joints.pop_front();
    if (got.joint !== want.joint) report("joint_index", got.joint, want.joint);
    if (got.lx !== want.lx) report("leg_x", got.lx, want.lx);
    if (got.ly !== want.ly) report("leg_y", got.ly, want.ly);
    if (got.lz !== want.lz) report("leg_z", got.lz, want.lz);
    if (got.bx !== want.bx) report("body_x", got.bx, want.bx);
    if (got.by !== want.by) report("body_y", got.by, want.by);
    if (got.bz !== want.bz) report("body_z", got.bz, want.bz);
    if (got.rx !== want.rx) report("rot_about_x", got.rx, want.rx);
    if (got.rz !== want.rz) report("rot_about_z", got.rz, want.rz);
    if (got.last !== want.last) report("last_joint", got.last, want.last);
  endtask
endclass

@@ test/testbench.sv @@
// Top-level testbench for the leg forward kinematics core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lfk_pkg::*;

  localparam int WatchdogLimit = 4000;
  // index past the last geometry register, writes to it are dropped
  localparam cfg_idx_t RegUnused = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  cfg_idx_t  cfg_idx_i = '0;
  cfg_data_t cfg_data_i = '0;

  int  send_gap_pct = 13;  // idle chance of the request side, percent
  int  recv_gap_pct = 45;  // stall chance of the result side, percent
  bit  hold_results = 1'b0; // long result-side stall in progress
  int  quiet_cycles = 0;

  lfk_req_if #(.ANGLE_WIDTH(16)) req_ch ();
  lfk_res_if #(.POS_WIDTH(24))   res_ch ();

  lfk_scoreboard joints = new();

  leg_forward_kinematics_core #(.POS_WIDTH(24), .ANGLE_WIDTH(16)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(req_ch.sink), .res_o(res_ch.source)
  );

  always #6 clk_i = ~clk_i;

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        joints.check_joint('{res_ch.joint_index, res_ch.leg_x, res_ch.leg_y, res_ch.leg_z,
                             res_ch.body_x, res_ch.body_y, res_ch.body_z,
                             res_ch.rot_about_x, res_ch.rot_about_z, res_ch.last_joint});
      res_ch.ready <= !hold_results && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one write, then a cycle with the enable low
  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    joints.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic load_geometry(cfg_data_t bh, oh, hx, hz, l1, l2);
    write_reg(RegBodyHeight, bh);
    write_reg(RegOriginToHip, oh);
    write_reg(RegHipOffsetX, hx);
    write_reg(RegHipOffsetZ, hz);
    write_reg(RegThighLength, l1);
    write_reg(RegShinLength, l2);
  endtask

  // Offer one request, idling first at random; returns after acceptance.
  task automatic send_request(logic [15:0] am, ay, ap, ak);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.mount_angle <= am;
    req_ch.yaw_angle <= ay;
    req_ch.pitch_angle <= ap;
    req_ch.knee_angle <= ak;
    do @(posedge clk_i); while (!req_ch.ready);
    joints.note_request(am, ay, ap, ak);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (joints.pending_joints.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Mostly common angles, sometimes one pinned to a quadrant edge.
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'(32'h4000 * $urandom_range(3) + $urandom_range(2) - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_batch(int n);
    repeat (n) send_request(pick_angle(), pick_angle(), pick_angle(), pick_angle());
  endtask

  initial begin
    logic [15:0] edges[8];
    edges = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
              16'h7FFF, 16'hFFFF, 16'h2000, 16'h0001};
    req_ch.valid <= 1'b0;
    req_ch.mount_angle <= '0;
    req_ch.yaw_angle <= '0;
    req_ch.pitch_angle <= '0;
    req_ch.knee_angle <= '0;
    joints.clear_geometry();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: everything sits at the origin.
    send_request(16'h1234, 16'h0100, 16'h0200, 16'h0300);
    drain();

    // Typical leg, directed quadrant edges on every angle.
    load_geometry(16'd1600, 16'd800, 16'hFF00, 16'h0040, 16'd1200, 16'd1800);
    foreach (edges[k]) send_request(edges[k], edges[(k + 1) % 8], edges[(k + 3) % 8],
                                    edges[(k + 5) % 8]);
    drain();

    // Largest lengths and offsets; angle sums wrap.
    load_geometry(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_request(16'h2000, 16'h6000, 16'hC000, 16'h4000);
    send_request(16'hA000, 16'h8000, 16'h7FFF, 16'h7FFF);
    drain();
    // Negative offsets the other way, out-of-range index ignored.
    load_geometry(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    write_reg(RegUnused, 16'hFFFF);
    send_request(16'h8000, 16'h8000, 16'h4000, 16'hC000);
    send_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    drain();

    // Phase 1: sender idles rarely, receiver often.
    load_geometry(16'd2400, 16'd960, 16'h0030, 16'hFFD0, 16'd1500, 16'd2000);
    random_batch(90);
    // Long receiver hold-off while requests keep coming: pipeline fills.
    fork
      begin
        hold_results <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_results <= 1'b0;
      end
      random_batch(20);
    join
    drain();

    // Phase 2: roles swapped, random geometry.
    send_gap_pct = 45;
    recv_gap_pct = 13;
    load_geometry(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()));
    random_batch(90);
    drain();

    // Phase 3: no idling on either side.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    load_geometry(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()));
    random_batch(95);
    drain();

    if (joints.mismatch_cnt == 0 && joints.pending_joints.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
